[rtl/core/shw_pkg.sv]
// ----------------------------------------------------------------------------
// shw_pkg: shared definitions for the sponge hash core
// Operation codes, result kinds, sequencer states and the result record.
// ----------------------------------------------------------------------------
package shw_pkg;

	localparam int WORD_W        = 64;
	localparam int CHAIN_LEN     = 8;
	localparam int ABSORB_ROUNDS = 12;
	localparam int FINAL_ROUNDS  = 8;
	localparam int ROT_WIDE      = 29;
	localparam int ROT_NARROW    = 16;

	typedef enum logic [1:0] {
		OP_LOAD_WORD = 2'd0,
		OP_LOAD_CTR  = 2'd1,
		OP_ABSORB    = 2'd2,
		OP_FINAL     = 2'd3
	} op_t;

	localparam logic KIND_COUNTER = 1'b0;
	localparam logic KIND_HASH    = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MIX,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              push;
		logic              kind;
		logic [WORD_W-1:0] value;
		logic              last;
	} result_t;

endpackage

[rtl/core/shw_mix_unit.sv]
// ----------------------------------------------------------------------------
// shw_mix_unit: one word step of a mix round
// Even words take add and rotate, odd words take XOR with the previous word.
// ----------------------------------------------------------------------------
module shw_mix_unit (
	input  logic [shw_pkg::WORD_W-1:0] cur,
	input  logic [shw_pkg::WORD_W-1:0] prev,
	input  logic [2:0]                 word_sel,
	output logic [shw_pkg::WORD_W-1:0] result
);

	logic [shw_pkg::WORD_W-1:0] sum;
	logic [shw_pkg::WORD_W-1:0] rot_wide;
	logic [shw_pkg::WORD_W-1:0] rot_narrow;

	assign sum        = cur + prev;
	assign rot_wide   = (sum << shw_pkg::ROT_WIDE) |
	                    (sum >> (shw_pkg::WORD_W - shw_pkg::ROT_WIDE));
	assign rot_narrow = (sum << shw_pkg::ROT_NARROW) |
	                    (sum >> (shw_pkg::WORD_W - shw_pkg::ROT_NARROW));

	always_comb begin
		if (word_sel[0]) begin
			result = cur ^ prev;
		end else if (word_sel[1]) begin
			result = rot_narrow;
		end else begin
			result = rot_wide;
		end
	end

endmodule

[rtl/core/shw_out_reg.sv]
// ----------------------------------------------------------------------------
// shw_out_reg: result output register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module shw_out_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  shw_pkg::result_t           res,
	output logic                       free,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       result_kind,
	output logic [shw_pkg::WORD_W-1:0] value,
	output logic                       last
);

	logic                       valid_q;
	logic                       kind_q;
	logic [shw_pkg::WORD_W-1:0] value_q;
	logic                       last_q;

	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.push) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.push) begin
			kind_q  <= res.kind;
			value_q <= res.value;
			last_q  <= res.last;
		end
	end

	assign out_valid   = valid_q;
	assign result_kind = kind_q;
	assign value       = value_q;
	assign last        = last_q;

endmodule

[rtl/core/sponge_hash_256_wide_words.sv]
// ----------------------------------------------------------------------------
// sponge_hash_256_wide_words: sponge hash core over eight 64-bit chain words
// Loads, absorbs and squeezes with one shared mix unit under a sequencer.
// ----------------------------------------------------------------------------
// Loads and data words that neither close a block nor end a call leave the
// sequencer idle; an end of call with nothing pending emits the counter result.
// A block mix runs ABSORB_ROUNDS rounds, one word step per cycle in the shared
// mix unit, and is followed by the counter result at an end of call. Finalize
// runs FINAL_ROUNDS rounds, then four hash words, one a cycle unless stalled.
// Reset clears the chain words, the block counter and the block position.
module sponge_hash_256_wide_words #(
	parameter int ABSORB_ROUNDS = shw_pkg::ABSORB_ROUNDS,
	parameter int FINAL_ROUNDS  = shw_pkg::FINAL_ROUNDS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 operation,
	input  logic [2:0]                 word_index,
	input  logic [shw_pkg::WORD_W-1:0] data_word,
	input  logic [3:0]                 byte_count,
	input  logic                       end_of_call,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       result_kind,
	output logic [shw_pkg::WORD_W-1:0] value,
	output logic                       last
);

	localparam int MAX_ROUNDS = (ABSORB_ROUNDS > FINAL_ROUNDS) ? ABSORB_ROUNDS : FINAL_ROUNDS;
	localparam int STEP_W     = $clog2(MAX_ROUNDS * shw_pkg::CHAIN_LEN);
	localparam logic [STEP_W-1:0] ABS_LAST = STEP_W'(ABSORB_ROUNDS * shw_pkg::CHAIN_LEN - 1);
	localparam logic [STEP_W-1:0] FIN_LAST = STEP_W'(FINAL_ROUNDS * shw_pkg::CHAIN_LEN - 1);

	localparam int W = shw_pkg::WORD_W;

	shw_pkg::state_t  state_q, state_d;
	shw_pkg::result_t res;

	logic [W-1:0]      chain_q [shw_pkg::CHAIN_LEN];
	logic [W-1:0]      chain_d [shw_pkg::CHAIN_LEN];
	logic [W-1:0]      ctr_q;
	logic [W-1:0]      ctr_inc;
	logic [1:0]        wib_q;
	logic [1:0]        wib_next;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        emit_cnt_q;
	logic              fin_q;
	logic              emit_q;

	logic         accept;
	logic         out_free;
	logic         step_done;
	logic         emit_done;
	logic         word_en;
	logic         full_blk;
	logic         partial_blk;
	logic         mix_need;
	logic [5:0]   shamt;
	logic [W-1:0] pad_bit;
	logic [W-1:0] abs_word;
	logic [W-1:0] c0_term;
	logic [W-1:0] mix_out;

	assign accept    = in_valid && !in_stall;
	assign ctr_inc   = ctr_q + {{(W-1){1'b0}}, 1'b1};
	assign step_done = step_q == (fin_q ? FIN_LAST : ABS_LAST);
	assign emit_done = !fin_q || (emit_cnt_q == 2'd3);

	// Short words are cut to their bytes and padded with a 1 bit above them.
	assign shamt    = {byte_count[2:0], 3'b000};
	assign pad_bit  = {{(W-1){1'b0}}, 1'b1} << shamt;
	assign abs_word = byte_count[3] ? data_word : ((data_word & (pad_bit - 1'b1)) | pad_bit);

	assign word_en     = (operation == shw_pkg::OP_ABSORB) && (byte_count != 4'd0);
	assign full_blk    = word_en && (wib_q == 2'd3);
	assign wib_next    = word_en ? wib_q + 2'd1 : wib_q;
	assign partial_blk = (operation == shw_pkg::OP_ABSORB) && end_of_call && !full_blk &&
	                     (wib_next != 2'd0);
	assign mix_need    = full_blk || partial_blk;
	assign c0_term     = full_blk ? ctr_inc : (partial_blk ? ctr_q : '0);

	shw_mix_unit u_mix (
		.cur      (chain_q[0]),
		.prev     (chain_q[shw_pkg::CHAIN_LEN-1]),
		.word_sel (step_q[2:0]),
		.result   (mix_out)
	);

	shw_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.free        (out_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.value       (value),
		.last        (last)
	);

	// The chain rotates by one word per mix step, so position 0 always holds
	// the word being mixed and the last position the one just finished.
	always_comb begin
		for (int i = 0; i < shw_pkg::CHAIN_LEN; i++) begin
			chain_d[i] = chain_q[i];
		end
		if (state_q == shw_pkg::ST_MIX) begin
			for (int i = 0; i < shw_pkg::CHAIN_LEN - 1; i++) begin
				chain_d[i] = chain_q[i+1];
			end
			chain_d[shw_pkg::CHAIN_LEN-1] = mix_out;
		end else if (accept) begin
			case (operation)
				shw_pkg::OP_LOAD_WORD: begin
					for (int i = 0; i < shw_pkg::CHAIN_LEN; i++) begin
						if (word_index == 3'(i)) begin
							chain_d[i] = data_word;
						end
					end
				end
				shw_pkg::OP_ABSORB: begin
					for (int i = 0; i < 4; i++) begin
						if (word_en && (wib_q == 2'(i))) begin
							chain_d[i] = chain_d[i] ^ abs_word;
						end
					end
					chain_d[0] = chain_d[0] ^ c0_term;
				end
				shw_pkg::OP_FINAL: begin
					chain_d[shw_pkg::CHAIN_LEN-1] = chain_q[shw_pkg::CHAIN_LEN-1] ^
					                                {{(W-1){1'b0}}, 1'b1};
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			shw_pkg::ST_IDLE: begin
				if (accept) begin
					if (operation == shw_pkg::OP_FINAL) begin
						state_d = shw_pkg::ST_MIX;
					end else if (operation == shw_pkg::OP_ABSORB) begin
						if (mix_need) begin
							state_d = shw_pkg::ST_MIX;
						end else if (end_of_call) begin
							state_d = shw_pkg::ST_EMIT;
						end
					end
				end
			end
			shw_pkg::ST_MIX: begin
				if (step_done) begin
					state_d = emit_q ? shw_pkg::ST_EMIT : shw_pkg::ST_IDLE;
				end
			end
			shw_pkg::ST_EMIT: begin
				if (out_free && emit_done) begin
					state_d = shw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = shw_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = state_q != shw_pkg::ST_IDLE;
		res.push  = (state_q == shw_pkg::ST_EMIT) && out_free;
		res.kind  = fin_q ? shw_pkg::KIND_HASH : shw_pkg::KIND_COUNTER;
		res.value = fin_q ? chain_q[{1'b0, emit_cnt_q}] : ctr_q;
		res.last  = emit_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= shw_pkg::ST_IDLE;
			ctr_q      <= '0;
			wib_q      <= '0;
			step_q     <= '0;
			emit_cnt_q <= '0;
			fin_q      <= 1'b0;
			emit_q     <= 1'b0;
			for (int i = 0; i < shw_pkg::CHAIN_LEN; i++) begin
				chain_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			for (int i = 0; i < shw_pkg::CHAIN_LEN; i++) begin
				chain_q[i] <= chain_d[i];
			end
			case (state_q)
				shw_pkg::ST_IDLE: begin
					step_q     <= '0;
					emit_cnt_q <= '0;
					if (accept) begin
						case (operation)
							shw_pkg::OP_LOAD_CTR: begin
								ctr_q <= data_word;
							end
							shw_pkg::OP_ABSORB: begin
								fin_q  <= 1'b0;
								emit_q <= end_of_call;
								wib_q  <= mix_need ? 2'd0 : wib_next;
							end
							shw_pkg::OP_FINAL: begin
								fin_q  <= 1'b1;
								emit_q <= 1'b1;
								wib_q  <= 2'd0;
							end
							default: begin
							end
						endcase
					end
				end
				shw_pkg::ST_MIX: begin
					step_q <= step_q + 1'b1;
					if (step_done && !fin_q) begin
						ctr_q <= ctr_inc;
					end
				end
				shw_pkg::ST_EMIT: begin
					if (out_free) begin
						emit_cnt_q <= emit_cnt_q + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shw_pkg::ST_MIX && step_done && !fin_q) |=> ctr_q == $past(ctr_inc))
		else $error("block counter did not advance after an absorb mix");

	assert property (@(posedge clk) disable iff (!arst_n)
		res.push |-> state_q == shw_pkg::ST_EMIT)
		else $error("result word pushed outside the emit phase");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res.push && res.kind == shw_pkg::KIND_HASH && res.last) |-> emit_cnt_q == 2'd3)
		else $error("hash marked last before the fourth word");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shw_pkg::ST_MIX) |-> wib_q == 2'd0)
		else $error("block position not cleared during a mix");

endmodule

[bench/tb_sponge_hash_256_wide_words.sv]
// ----------------------------------------------------------------------------
// tb_sponge_hash_256_wide_words: self-checking bench for the sponge hash core
// A short table of directed words goes first: extremes, loads, short and empty
// words, counter wrap, and finalize in the middle of a call. Absorb calls,
// finalizes, loads and noise follow at random. A model of the chain words
// predicts each untyped result. Both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
module tb_sponge_hash_256_wide_words;

	localparam int RANDOM_WORDS   = 255;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 200;
	localparam logic [63:0] ONES  = {64{1'b1}};

	typedef struct packed {
		logic        kind;
		logic [63:0] val;
		logic        last;
	} hash_res_t;

	typedef struct packed {
		shw_pkg::op_t op;
		logic [2:0]   idx;
		logic [63:0]  data;
		logic [3:0]   nbytes;
		logic         eoc;
		logic         typed;
		logic [63:0]  typed_val;
	} stim_row_t;

	localparam int N_ROWS = 25;

	stim_row_t directed_rows [0:N_ROWS-1] = '{
		'{shw_pkg::OP_ABSORB,    3'd0, 64'd0,                  4'd0,  1'b1, 1'b1, 64'd0},
		'{shw_pkg::OP_LOAD_CTR,  3'd0, ONES,                   4'd0,  1'b0, 1'b0, 64'd0},
		'{shw_pkg::OP_ABSORB,    3'd0, 64'd0,                  4'd0,  1'b1, 1'b1, ONES},
		'{shw_pkg::OP_ABSORB,    3'd0, 64'h0123_4567_89ab_cdef, 4'd3,  1'b1, 1'b1, 64'd0},
		'{shw_pkg::OP_LOAD_WORD, 3'd0, ONES,                   4'd0,  1'b0, 1'b0, 64'd0},
		'{shw_pkg::OP_LOAD_WORD, 3'd7, 64'd0,                  4'd15, 1'b1, 1'b0, 64'd0},
		'{shw_pkg::OP_LOAD_WORD, 3'd5, 64'haaaa_aaaa_aaaa_aaaa, 4'd8,  1'b0, 1'b0, 64'd0},
		'{shw_pkg::OP_LOAD_WORD, 3'd2, 64'h5555_5555_5555_5555, 4'd0,  1'b0, 1'b0, 64'd0},
		'{shw_pkg::OP_LOAD_CTR,  3'd7, 64'd0,                  4'd0,  1'b0, 1'b0, 64'd0},
		'{shw_pkg::OP_ABSORB,    3'd0, ONES,                   4'd8,  1'b0, 1'b0, 64'd0},
		'{shw_pkg::OP_ABSORB,    3'd5, 64'd0,                  4'd15, 1'b0, 1'b0, 64'd0},
		'{shw_pkg::OP_ABSORB,    3'd2, 64'h5555_5555_5555_5555, 4'd9,  1'b0, 1'b0, 64'd0},
		'{shw_pkg::OP_ABSORB,    3'd0, 64'haaaa_aaaa_aaaa_aaaa, 4'd8,  1'b1, 1'b1, 64'd1},
		'{shw_pkg::OP_ABSORB,    3'd0, ONES,                   4'd0,  1'b0, 1'b0, 64'd0},
		'{shw_pkg::OP_ABSORB,    3'd0, ONES,                   4'd1,  1'b0, 1'b0, 64'd0},
		'{shw_pkg::OP_ABSORB,    3'd0, ONES,                   4'd7,  1'b0, 1'b0, 64'd0},
		'{shw_pkg::OP_LOAD_WORD, 3'd3, 64'hdead_beef_0bad_f00d, 4'd0,  1'b0, 1'b0, 64'd0},
		'{shw_pkg::OP_LOAD_CTR,  3'd0, 64'h8000_0000_0000_0000, 4'd0,  1'b0, 1'b0, 64'd0},
		'{shw_pkg::OP_ABSORB,    3'd0, 64'hfedc_ba98_7654_3210, 4'd4,  1'b1, 1'b0, 64'd0},
		'{shw_pkg::OP_ABSORB,    3'd0, ONES,                   4'd8,  1'b0, 1'b0, 64'd0},
		'{shw_pkg::OP_FINAL,     3'd0, 64'd0,                  4'd0,  1'b0, 1'b0, 64'd0},
		'{shw_pkg::OP_ABSORB,    3'd0, ONES,                   4'd8,  1'b1, 1'b0, 64'd0},
		'{shw_pkg::OP_FINAL,     3'd7, ONES,                   4'd15, 1'b1, 1'b0, 64'd0},
		'{shw_pkg::OP_LOAD_WORD, 3'd1, ONES,                   4'd15, 1'b1, 1'b0, 64'd0},
		'{shw_pkg::OP_FINAL,     3'd0, 64'd0,                  4'd0,  1'b0, 1'b0, 64'd0}
	};

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [1:0]  operation   = shw_pkg::OP_LOAD_WORD;
	logic [2:0]  word_index  = 3'd0;
	logic [63:0] data_word   = 64'd0;
	logic [3:0]  byte_count  = 4'd0;
	logic        end_of_call = 1'b0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic        result_kind;
	logic [63:0] value;
	logic        last;

	logic [63:0] chain_st [0:7];
	logic [63:0] ctr_st;
	logic [1:0]  pos_st;

	hash_res_t   pending_results [$];
	hash_res_t   head_res;
	int          mismatch_count = 0;
	int          quiet_cycles   = 0;
	logic        quiet_phase    = 1'b0;

	sponge_hash_256_wide_words i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.word_index  (word_index),
		.data_word   (data_word),
		.byte_count  (byte_count),
		.end_of_call (end_of_call),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.value       (value),
		.last        (last)
	);

	always #10 clk = ~clk;

	function automatic logic [63:0] rotl64(input logic [63:0] v, input int amount);
		return (v << amount) | (v >> (64 - amount));
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic mix_chain(input int rounds);
		logic [63:0] prev;
		for (int r = 0; r < rounds; r++) begin
			for (int w = 0; w < 8; w++) begin
				prev = chain_st[(w + 7) % 8];
				if (w % 2 == 0) begin
					chain_st[w] = rotl64(chain_st[w] + prev,
						(w % 4 == 0) ? shw_pkg::ROT_WIDE : shw_pkg::ROT_NARROW);
				end else begin
					chain_st[w] = chain_st[w] ^ prev;
				end
			end
		end
	endtask

	task automatic hash_step(input shw_pkg::op_t op, input logic [2:0] idx,
			input logic [63:0] data, input logic [3:0] nbytes, input logic eoc,
			output hash_res_t res [0:3], output int n_res);
		logic [3:0]  nb;
		logic [63:0] word;
		n_res = 0;
		case (op)
			shw_pkg::OP_LOAD_WORD: begin
				chain_st[idx] = data;
			end
			shw_pkg::OP_LOAD_CTR: begin
				ctr_st = data;
			end
			shw_pkg::OP_ABSORB: begin
				nb = (nbytes > 4'd8) ? 4'd8 : nbytes;
				if (nb != 4'd0) begin
					word = data;
					if (nb < 4'd8) begin
						word = word & ((64'd1 << (nb * 8)) - 64'd1);
						word = word | (64'd1 << (nb * 8));
					end
					chain_st[pos_st] = chain_st[pos_st] ^ word;
					if (pos_st == 2'd3) begin
						chain_st[0] = chain_st[0] ^ (ctr_st + 64'd1);
						mix_chain(shw_pkg::ABSORB_ROUNDS);
						ctr_st = ctr_st + 64'd1;
						pos_st = 2'd0;
					end else begin
						pos_st = pos_st + 2'd1;
					end
				end
				if (eoc) begin
					if (pos_st != 2'd0) begin
						chain_st[0] = chain_st[0] ^ ctr_st;
						mix_chain(shw_pkg::ABSORB_ROUNDS);
						ctr_st = ctr_st + 64'd1;
						pos_st = 2'd0;
					end
					res[0] = '{shw_pkg::KIND_COUNTER, ctr_st, 1'b1};
					n_res = 1;
				end
			end
			default: begin
				chain_st[7] = chain_st[7] ^ 64'd1;
				mix_chain(shw_pkg::FINAL_ROUNDS);
				pos_st = 2'd0;
				for (int i = 0; i < 4; i++) begin
					res[i] = '{shw_pkg::KIND_HASH, chain_st[i], (i == 3)};
				end
				n_res = 4;
			end
		endcase
	endtask

	task automatic issue_word(input shw_pkg::op_t op, input logic [2:0] idx,
			input logic [63:0] data, input logic [3:0] nbytes, input logic eoc,
			input logic typed, input logic [63:0] typed_val);
		hash_res_t res [0:3];
		int        n_res;
		if (!quiet_phase && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		word_index  <= idx;
		data_word   <= data;
		byte_count  <= nbytes;
		end_of_call <= eoc;
		do @(posedge clk); while (in_stall !== 1'b0);
		hash_step(op, idx, data, nbytes, eoc, res, n_res);
		if (typed) begin
			pending_results.push_back('{shw_pkg::KIND_COUNTER, typed_val, 1'b1});
		end else begin
			for (int i = 0; i < n_res; i++) pending_results.push_back(res[i]);
		end
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result kind %0d value %h last %0d",
					$time, result_kind, value, last);
				mismatch_count++;
			end else begin
				head_res = pending_results.pop_front();
				if (result_kind !== head_res.kind) begin
					$display("%0t: result_kind expected %0d actual %0d",
						$time, head_res.kind, result_kind);
					mismatch_count++;
				end
				if (value !== head_res.val) begin
					$display("%0t: value expected %h actual %h", $time, head_res.val, value);
					mismatch_count++;
				end
				if (last !== head_res.last) begin
					$display("%0t: last expected %0d actual %0d", $time, head_res.last, last);
					mismatch_count++;
				end
			end
		end
		out_stall <= !quiet_phase && ($urandom_range(99) < 17);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int         n_random;
		int         sel;
		int         n_words;
		logic [3:0] nb;
		for (int i = 0; i < 8; i++) chain_st[i] = 64'd0;
		ctr_st   = 64'd0;
		pos_st   = 2'd0;
		n_random = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			issue_word(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].data,
				directed_rows[i].nbytes, directed_rows[i].eoc,
				directed_rows[i].typed, directed_rows[i].typed_val);
		end
		hold_until_drained();

		while (n_random < RANDOM_WORDS) begin
			quiet_phase = (n_random >= 120 && n_random < 180);
			sel = $urandom_range(99);
			if (sel < 60) begin
				n_words = $urandom_range(1, 9);
				for (int k = 0; k < n_words; k++) begin
					if (k != n_words - 1) begin
						nb = ($urandom_range(19) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
					end else begin
						case ($urandom_range(3))
							0: nb = 4'd8;
							1: nb = 4'($urandom_range(9, 15));
							default: nb = 4'($urandom_range(0, 7));
						endcase
					end
					issue_word(shw_pkg::OP_ABSORB, 3'($urandom_range(7)), rand64(), nb,
						(k == n_words - 1), 1'b0, 64'd0);
					n_random++;
				end
			end else if (sel < 75) begin
				issue_word(shw_pkg::OP_FINAL, 3'($urandom_range(7)), rand64(),
					4'($urandom_range(15)), 1'($urandom_range(1)), 1'b0, 64'd0);
				n_random++;
			end else if (sel < 82) begin
				issue_word(shw_pkg::OP_LOAD_WORD, 3'($urandom_range(7)), rand64(),
					4'($urandom_range(15)), 1'($urandom_range(1)), 1'b0, 64'd0);
				n_random++;
			end else if (sel < 86) begin
				issue_word(shw_pkg::OP_LOAD_CTR, 3'($urandom_range(7)),
					($urandom_range(1) == 0) ? ONES - 64'($urandom_range(3)) : rand64(),
					4'($urandom_range(15)), 1'($urandom_range(1)), 1'b0, 64'd0);
				n_random++;
			end else begin
				issue_word(shw_pkg::op_t'($urandom_range(3)), 3'($urandom_range(7)), rand64(),
					4'($urandom_range(15)), 1'($urandom_range(1)), 1'b0, 64'd0);
				n_random++;
			end
			if ($urandom_range(9) == 0) hold_until_drained();
		end
		quiet_phase = 1'b0;

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
